// ===== hdl/rti_pkg.sv =====
// Shared types and constants of the ray/triangle intersection tester.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none
package rti_pkg;

   // Fixed-point format of all coordinates: signed Q(31-F).F.
   localparam int FRAC_BITS = 16;

   localparam int CW     = 32;            // coordinate width
   localparam int EW     = CW + 1;        // edge and origin-offset width
   localparam int PW     = 2 * EW + 1;    // cross product component width
   localparam int SPLIT  = PW / 2;        // low slice of a cross component per multiplier
   localparam int HW     = PW - SPLIT;    // high slice of a cross component
   localparam int DW     = 104;           // dot product width, signed
   localparam int UW     = DW;            // magnitude width fed to the dividers
   localparam int QW     = CW + 1;        // quotient bits produced per division
   localparam int EPS_W  = 16;
   localparam int BARY_W = 17;
   localparam int IDX_W  = 3;

   localparam logic [BARY_W-1:0] BARY_MAX = {BARY_W{1'b1}};
   localparam logic [CW-1:0] DIST_POS_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] DIST_NEG_MAX = {1'b1, {(CW-1){1'b0}}};

   // Register indexes of the configuration port.
   localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;
   localparam logic [IDX_W-1:0] REG_EPSILON  = 3'd6;

   localparam logic [CW-1:0]    DIR_Z_RESET = 32'd65536;
   localparam logic [EPS_W-1:0] EPS_RESET   = 16'd7;

   typedef struct packed {
      logic signed [CW-1:0] vert0_x;
      logic signed [CW-1:0] vert0_y;
      logic signed [CW-1:0] vert0_z;
      logic signed [CW-1:0] vert1_x;
      logic signed [CW-1:0] vert1_y;
      logic signed [CW-1:0] vert1_z;
      logic signed [CW-1:0] vert2_x;
      logic signed [CW-1:0] vert2_y;
      logic signed [CW-1:0] vert2_z;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic signed [CW-1:0] hit_distance;
      logic [BARY_W-1:0]    bary_u;
      logic [BARY_W-1:0]    bary_v;
   } rsp_type;

   // Control bits that ride alongside the division pipelines.
   typedef struct packed {
      logic valid;
      logic hit;
      logic neg;   // distance is negative
      logic big;   // distance quotient exceeds the quotient range
   } sb_type;

endpackage
`default_nettype wire

// ===== hdl/rti_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rti_pkg for the operand and quotient widths.
`default_nettype none
module rti_divider (
   input  logic                     clock,
   input  logic [rti_pkg::UW-1:0]   num_hi,   // dividend shifted down by QW, below den
   input  logic [rti_pkg::QW-1:0]   num_lo,   // low QW dividend bits, MSB first
   input  logic [rti_pkg::UW-1:0]   den,
   output logic [rti_pkg::QW-1:0]   quo
);

   logic [rti_pkg::UW-1:0] rem_ff [1:rti_pkg::QW-1];
   logic [rti_pkg::QW-1:0] lo_ff  [1:rti_pkg::QW-1];
   logic [rti_pkg::UW-1:0] den_ff [1:rti_pkg::QW-1];
   logic [rti_pkg::QW-1:0] quo_ff [1:rti_pkg::QW];

   for (genvar g = 1; g <= rti_pkg::QW; g++) begin : g_step
      logic [rti_pkg::UW-1:0] rem_src;
      logic [rti_pkg::QW-1:0] lo_src;
      logic [rti_pkg::UW-1:0] den_src;
      logic [rti_pkg::QW-1:0] quo_src;
      logic [rti_pkg::UW:0]   trial;
      logic                   take;

      if (g == 1) begin : g_first
         assign rem_src = num_hi;
         assign lo_src  = num_lo;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign lo_src  = lo_ff[g-1];
         assign den_src = den_ff[g-1];
         assign quo_src = quo_ff[g-1];
      end

      // Bring down the next dividend bit and subtract the divisor when it fits.
      assign trial = {rem_src, lo_src[rti_pkg::QW-1]};
      assign take  = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         quo_ff[g] <= {quo_src[rti_pkg::QW-2:0], take};
      end

      if (g < rti_pkg::QW) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[g] <= take ? rti_pkg::UW'(trial - {1'b0, den_src})
                              : trial[rti_pkg::UW-1:0];
            lo_ff[g]  <= {lo_src[rti_pkg::QW-2:0], 1'b0};
            den_ff[g] <= den_src;
         end
      end
   end

   assign quo = quo_ff[rti_pkg::QW];

endmodule
`default_nettype wire

// ===== hdl/ray_triangle_intersect.sv =====
// Top level of the two-sided ray/triangle intersection tester in exact fixed point.
// Depends on rti_pkg and instantiates three rti_divider pipelines.
`default_nettype none
// The block tests one triangle per clock against the ray held in its registers.
// A triangle is transferred at any rising edge with start high; busy never rises,
// so a new triangle may follow in every cycle. Each triangle yields exactly one
// result, in order, after passing through these stages in turn:
// eight stages of edge, cross product, dot product, sign and bound logic, then the
// 33 stages of the quotient pipelines that form distance, u and v one bit per
// stage, then the output register. The result appears on rsp_data for one cycle
// with rsp_strobe high and is not held, so the receiver must take it in that cycle.
// The ray registers are read in stage 1 and epsilon in stage 8 while triangles are
// in flight, so write them only while no triangle is in the pipeline.
module ray_triangle_intersect (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  rti_pkg::req_type               req_data,
   output logic                           rsp_strobe,
   output rti_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [rti_pkg::IDX_W-1:0]      csr_index,
   input  logic [rti_pkg::CW-1:0]         csr_wdata
);

   localparam int LATENCY = rti_pkg::QW + 9;

   // Dot product slots.
   localparam int DOT_DET = 0;
   localparam int DOT_U   = 1;
   localparam int DOT_V   = 2;
   localparam int DOT_T   = 3;

   localparam int EW = rti_pkg::EW;
   localparam int PW = rti_pkg::PW;
   localparam int DW = rti_pkg::DW;
   localparam int UW = rti_pkg::UW;
   localparam int QW = rti_pkg::QW;
   localparam int ML_W = EW + rti_pkg::SPLIT + 1;
   localparam int MH_W = EW + rti_pkg::HW;

   // Index of the next vector component, wrapping from 2 to 0.
   function automatic int nxt(input int i);
      return (i == 2) ? 0 : i + 1;
   endfunction

   function automatic logic [rti_pkg::BARY_W-1:0] sat_bary(input logic [QW-1:0] q);
      return (q > QW'(rti_pkg::BARY_MAX)) ? rti_pkg::BARY_MAX : q[rti_pkg::BARY_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------------
   logic signed [rti_pkg::CW-1:0] org_ff [3];
   logic signed [rti_pkg::CW-1:0] dir_ff [3];
   logic [rti_pkg::EPS_W-1:0]     eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= rti_pkg::DIR_Z_RESET;
         eps_ff    <= rti_pkg::EPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rti_pkg::REG_ORIGIN_X: org_ff[0] <= csr_wdata;
            rti_pkg::REG_ORIGIN_Y: org_ff[1] <= csr_wdata;
            rti_pkg::REG_ORIGIN_Z: org_ff[2] <= csr_wdata;
            rti_pkg::REG_DIR_X:    dir_ff[0] <= csr_wdata;
            rti_pkg::REG_DIR_Y:    dir_ff[1] <= csr_wdata;
            rti_pkg::REG_DIR_Z:    dir_ff[2] <= csr_wdata;
            rti_pkg::REG_EPSILON:  eps_ff    <= csr_wdata[rti_pkg::EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline never stalls, so every start is a transfer.
   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   logic signed [rti_pkg::CW-1:0] v0 [3];
   logic signed [rti_pkg::CW-1:0] v1 [3];
   logic signed [rti_pkg::CW-1:0] v2 [3];

   assign v0[0] = req_data.vert0_x;
   assign v0[1] = req_data.vert0_y;
   assign v0[2] = req_data.vert0_z;
   assign v1[0] = req_data.vert1_x;
   assign v1[1] = req_data.vert1_y;
   assign v1[2] = req_data.vert1_z;
   assign v2[0] = req_data.vert2_x;
   assign v2[1] = req_data.vert2_y;
   assign v2[2] = req_data.vert2_z;

   // Valid bits of stages one to seven; stage eight and on carry a sideband struct.
   logic [7:1] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:1], accept};
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: edges E1, E2 and the origin offset. The offset is always taken as
   // O - V0; when the determinant turns out non-positive every quantity built
   // from it simply changes sign, which stage 7 applies.
   // ---------------------------------------------------------------------------
   logic signed [EW-1:0] s1_e1_ff [3];
   logic signed [EW-1:0] s1_e2_ff [3];
   logic signed [EW-1:0] s1_t_ff  [3];
   logic signed [EW-1:0] s1_d_ff  [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s1_e1_ff[i] <= EW'(v1[i]) - EW'(v0[i]);
         s1_e2_ff[i] <= EW'(v2[i]) - EW'(v0[i]);
         s1_t_ff[i]  <= EW'(org_ff[i]) - EW'(v0[i]);
         s1_d_ff[i]  <= EW'(dir_ff[i]);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: the twelve products of P = D x E2 and Q = T x E1.
   // ---------------------------------------------------------------------------
   logic signed [2*EW-1:0] s2_pa_ff [3];
   logic signed [2*EW-1:0] s2_pb_ff [3];
   logic signed [2*EW-1:0] s2_qa_ff [3];
   logic signed [2*EW-1:0] s2_qb_ff [3];
   logic signed [EW-1:0]   s2_e1_ff [3];
   logic signed [EW-1:0]   s2_e2_ff [3];
   logic signed [EW-1:0]   s2_t_ff  [3];
   logic signed [EW-1:0]   s2_d_ff  [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s2_pa_ff[i] <= s1_d_ff[nxt(i)] * s1_e2_ff[nxt(nxt(i))];
         s2_pb_ff[i] <= s1_d_ff[nxt(nxt(i))] * s1_e2_ff[nxt(i)];
         s2_qa_ff[i] <= s1_t_ff[nxt(i)] * s1_e1_ff[nxt(nxt(i))];
         s2_qb_ff[i] <= s1_t_ff[nxt(nxt(i))] * s1_e1_ff[nxt(i)];
         s2_e1_ff[i] <= s1_e1_ff[i];
         s2_e2_ff[i] <= s1_e2_ff[i];
         s2_t_ff[i]  <= s1_t_ff[i];
         s2_d_ff[i]  <= s1_d_ff[i];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: cross product components.
   // ---------------------------------------------------------------------------
   logic signed [PW-1:0] s3_p_ff  [3];
   logic signed [PW-1:0] s3_q_ff  [3];
   logic signed [EW-1:0] s3_e1_ff [3];
   logic signed [EW-1:0] s3_e2_ff [3];
   logic signed [EW-1:0] s3_t_ff  [3];
   logic signed [EW-1:0] s3_d_ff  [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s3_p_ff[i]  <= PW'(s2_pa_ff[i]) - PW'(s2_pb_ff[i]);
         s3_q_ff[i]  <= PW'(s2_qa_ff[i]) - PW'(s2_qb_ff[i]);
         s3_e1_ff[i] <= s2_e1_ff[i];
         s3_e2_ff[i] <= s2_e2_ff[i];
         s3_t_ff[i]  <= s2_t_ff[i];
         s3_d_ff[i]  <= s2_d_ff[i];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: partial products of the four dot products. Each cross component is
   // split into an unsigned low slice and a signed high slice so that every
   // multiplier stays near 33 by 34 bits.
   // ---------------------------------------------------------------------------
   logic signed [EW-1:0] dot_a [4][3];
   logic signed [PW-1:0] dot_b [4][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dot_a[DOT_DET][i] = s3_e1_ff[i];
         dot_b[DOT_DET][i] = s3_p_ff[i];
         dot_a[DOT_U][i]   = s3_t_ff[i];
         dot_b[DOT_U][i]   = s3_p_ff[i];
         dot_a[DOT_V][i]   = s3_d_ff[i];
         dot_b[DOT_V][i]   = s3_q_ff[i];
         dot_a[DOT_T][i]   = s3_e2_ff[i];
         dot_b[DOT_T][i]   = s3_q_ff[i];
      end
   end

   logic signed [ML_W-1:0] s4_ml_ff [4][3];
   logic signed [MH_W-1:0] s4_mh_ff [4][3];

   always_ff @(posedge clock) begin
      for (int n = 0; n < 4; n++) begin
         for (int i = 0; i < 3; i++) begin
            s4_ml_ff[n][i] <= dot_a[n][i]
                              * $signed({1'b0, dot_b[n][i][rti_pkg::SPLIT-1:0]});
            s4_mh_ff[n][i] <= dot_a[n][i] * $signed(dot_b[n][i][PW-1:rti_pkg::SPLIT]);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: full products. Stage 6: dot product sums.
   // ---------------------------------------------------------------------------
   logic signed [DW-1:0] s5_term_ff [4][3];
   logic signed [DW-1:0] s6_sum_ff  [4];

   always_ff @(posedge clock) begin
      for (int n = 0; n < 4; n++) begin
         for (int i = 0; i < 3; i++) begin
            s5_term_ff[n][i] <= (DW'(s4_mh_ff[n][i]) <<< rti_pkg::SPLIT)
                                + DW'(s4_ml_ff[n][i]);
         end
         s6_sum_ff[n] <= s5_term_ff[n][0] + s5_term_ff[n][1] + s5_term_ff[n][2];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: two-sided handling. A positive determinant keeps the signs; a zero
   // or negative one is negated along with u, v and distance numerators.
   // ---------------------------------------------------------------------------
   logic signed [DW-1:0] det_raw;
   logic signed [DW-1:0] t_raw;
   logic                 det_pos;

   assign det_raw = s6_sum_ff[DOT_DET];
   assign t_raw   = s6_sum_ff[DOT_T];
   assign det_pos = !det_raw[DW-1] && (det_raw != '0);

   logic [UW-1:0]        s7_det_ff;
   logic signed [DW-1:0] s7_un_ff;
   logic signed [DW-1:0] s7_vn_ff;
   logic [UW-1:0]        s7_tmag_ff;
   logic                 s7_tneg_ff;

   always_ff @(posedge clock) begin
      s7_det_ff  <= det_pos ? UW'(det_raw) : UW'(-det_raw);
      s7_un_ff   <= det_pos ? s6_sum_ff[DOT_U] : -s6_sum_ff[DOT_U];
      s7_vn_ff   <= det_pos ? s6_sum_ff[DOT_V] : -s6_sum_ff[DOT_V];
      s7_tmag_ff <= t_raw[DW-1] ? UW'(-t_raw) : UW'(t_raw);
      s7_tneg_ff <= det_pos ? t_raw[DW-1] : (!t_raw[DW-1] && (t_raw != '0));
   end

   // ---------------------------------------------------------------------------
   // Stage 8: determinant and barycentric bounds, divider operands.
   // Each dividend is the numerator scaled by 2^FRAC_BITS; its part above the low
   // QW bits seeds the remainder. For u and v of a hit the numerator never exceeds the
   // determinant, so the seed is below it. For the distance the seed
   // reaching the determinant means the quotient overflows and saturates.
   // ---------------------------------------------------------------------------
   logic signed [DW-1:0] det_s;
   logic [UW-1:0]        eps_lim;
   logic signed [DW:0]   uv_sum;
   logic [UW-1:0]        un_u;
   logic [UW-1:0]        vn_u;
   logic [UW-1:0]        dist_hi_in;
   logic                 hit_in;

   assign det_s      = $signed(s7_det_ff);
   assign eps_lim    = UW'(eps_ff) << (2 * rti_pkg::FRAC_BITS);
   assign uv_sum     = (DW+1)'(s7_un_ff) + (DW+1)'(s7_vn_ff);
   assign un_u       = s7_un_ff;
   assign vn_u       = s7_vn_ff;
   assign dist_hi_in = s7_tmag_ff >> (QW - rti_pkg::FRAC_BITS);
   assign hit_in     = !((s7_det_ff == '0) || (s7_det_ff < eps_lim)
                         || s7_un_ff[DW-1] || (s7_un_ff > det_s)
                         || s7_vn_ff[DW-1] || (uv_sum > (DW+1)'(det_s)));

   rti_pkg::sb_type s8_sb_ff;
   logic [UW-1:0]   s8_den_ff;
   logic [UW-1:0]   s8_dhi_ff;
   logic [QW-1:0]   s8_dlo_ff;
   logic [UW-1:0]   s8_uhi_ff;
   logic [QW-1:0]   s8_ulo_ff;
   logic [UW-1:0]   s8_vhi_ff;
   logic [QW-1:0]   s8_vlo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_sb_ff <= '0;
      end else begin
         s8_sb_ff.valid <= vld_ff[7];
         s8_sb_ff.hit   <= hit_in;
         s8_sb_ff.neg   <= s7_tneg_ff;
         s8_sb_ff.big   <= dist_hi_in >= s7_det_ff;
      end
   end

   always_ff @(posedge clock) begin
      s8_den_ff <= s7_det_ff;
      s8_dhi_ff <= dist_hi_in;
      s8_dlo_ff <= QW'({s7_tmag_ff, {rti_pkg::FRAC_BITS{1'b0}}});
      s8_uhi_ff <= un_u >> (QW - rti_pkg::FRAC_BITS);
      s8_ulo_ff <= QW'({un_u, {rti_pkg::FRAC_BITS{1'b0}}});
      s8_vhi_ff <= vn_u >> (QW - rti_pkg::FRAC_BITS);
      s8_vlo_ff <= QW'({vn_u, {rti_pkg::FRAC_BITS{1'b0}}});
   end

   // ---------------------------------------------------------------------------
   // Quotient pipelines, with the sideband delayed to match them.
   // ---------------------------------------------------------------------------
   logic [QW-1:0] quo_dist;
   logic [QW-1:0] quo_u;
   logic [QW-1:0] quo_v;

   rti_divider u_div_dist (
      .clock  (clock),
      .num_hi (s8_dhi_ff),
      .num_lo (s8_dlo_ff),
      .den    (s8_den_ff),
      .quo    (quo_dist)
   );

   rti_divider u_div_u (
      .clock  (clock),
      .num_hi (s8_uhi_ff),
      .num_lo (s8_ulo_ff),
      .den    (s8_den_ff),
      .quo    (quo_u)
   );

   rti_divider u_div_v (
      .clock  (clock),
      .num_hi (s8_vhi_ff),
      .num_lo (s8_vlo_ff),
      .den    (s8_den_ff),
      .quo    (quo_v)
   );

   rti_pkg::sb_type sb_ff [1:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 1; j <= QW; j++) begin
            sb_ff[j] <= '0;
         end
      end else begin
         sb_ff[1] <= s8_sb_ff;
         for (int j = 2; j <= QW; j++) begin
            sb_ff[j] <= sb_ff[j-1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Output register: saturation, sign and zeroing of a miss.
   // ---------------------------------------------------------------------------
   rti_pkg::sb_type  sb_out;
   rti_pkg::rsp_type rsp_in;
   logic [QW-1:0]    q_neg_lim;

   assign sb_out    = sb_ff[QW];
   assign q_neg_lim = QW'(rti_pkg::DIST_NEG_MAX);

   always_comb begin
      rsp_in = '0;
      if (sb_out.hit) begin
         rsp_in.hit = 1'b1;
         if (sb_out.neg) begin
            rsp_in.hit_distance = (sb_out.big || (quo_dist > q_neg_lim))
                                  ? rti_pkg::DIST_NEG_MAX
                                  : -quo_dist[rti_pkg::CW-1:0];
         end else begin
            rsp_in.hit_distance = (sb_out.big || (quo_dist >= q_neg_lim))
                                  ? rti_pkg::DIST_POS_MAX
                                  : quo_dist[rti_pkg::CW-1:0];
         end
         rsp_in.bary_u = sat_bary(quo_u);
         rsp_in.bary_v = sat_bary(quo_v);
      end
   end

   logic             rsp_strobe_ff;
   rti_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sb_out.valid;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------

   // Every transferred triangle comes out after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("result missing at the expected latency");

   // A miss reports all fields zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |->
         (rsp_data.hit_distance == '0 && rsp_data.bary_u == '0 && rsp_data.bary_v == '0))
      else $error("miss with nonzero result fields");

   // Truncated u and v of a hit never sum beyond one.
   a_bary_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |->
         ((32'(rsp_data.bary_u) + 32'(rsp_data.bary_v)) <= (32'd1 << rti_pkg::FRAC_BITS)))
      else $error("barycentric sum above one");

   // A hit never reaches the dividers with a zero divisor.
   a_nonzero_den: assert property (@(posedge clock) disable iff (reset)
      (s8_sb_ff.valid && s8_sb_ff.hit) |-> (s8_den_ff != '0))
      else $error("hit with zero determinant");

endmodule
`default_nettype wire
